/* design/server_pick_balancer_top_defines.svh */
// Assertion macros of the server pick balancer, included by its top level.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef SERVER_PICK_BALANCER_TOP_DEFINES_SVH
`define SERVER_PICK_BALANCER_TOP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be true outside reset.
`define SPB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* design/spb_pkg.sv */
// Shared constants and codes of the server pick balancer.
// Used by the channel interfaces and the top level; depends on nothing.
package spb_pkg;

  localparam int MAX_SERVERS = 8;
  localparam int SRV_W       = $clog2(MAX_SERVERS);
  localparam int CNT_W       = 4;
  localparam int WEIGHT_BITS = 8;
  localparam int CONN_BITS   = 16;
  localparam int CREDIT_W    = 12;
  localparam int OPEN_W      = 16;
  localparam int MODE_W      = 2;
  localparam int MASK_W      = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_PACKED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEALTHY_MASK   = 2'd3;

  localparam logic [MODE_W-1:0] MODE_RR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SWRR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LC   = 2'd2;

  localparam logic FUNC_PICK = 1'b0;
  localparam logic FUNC_DONE = 1'b1;

endpackage

/* design/spb_req_if.sv */
// Request channel of the server pick balancer: valid, ready and the request fields.
// Depends on spb_pkg.
interface spb_req_if;
  import spb_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [SRV_W-1:0] done_server;

  modport source (output valid, output func, output done_server, input ready);
  modport sink   (input valid, input func, input done_server, output ready);

endinterface

/* design/spb_res_if.sv */
// Result channel of the server pick balancer: valid, ready and the result fields.
// Depends on spb_pkg.
interface spb_res_if;
  import spb_pkg::*;

  logic              valid;
  logic              ready;
  logic [SRV_W-1:0]  server_index;
  logic              no_server;
  logic [OPEN_W-1:0] open_count;

  modport source (output valid, output server_index, output no_server, output open_count,
                  input ready);
  modport sink   (input valid, input server_index, input no_server, input open_count,
                  output ready);

endinterface

/* design/server_pick_balancer_top.sv */
// Server pick balancer: round robin, smooth weighted round robin and least connection.
// Depends on spb_pkg, spb_req_if, spb_res_if, spb_ram and the assertion macro header.
//
// Each request picks a backend server, or for a finished connection lowers that server's
// count; every accepted request gives exactly one result. Requests are handled one at a
// time. When the pool is empty or the mode is invalid the result is formed on acceptance;
// round robin and finished connections first read one connection entry, least connection
// scans n connection entries, and weighted mode scans n credit entries and, if a server is
// healthy, then writes back the chosen credit and reads its connection count. Here n is the
// server count (at most eight); the credit and connection tables sit in memories that are
// read one entry per cycle. A result waiting in the output register does not block the next
// request. Writing the server count clears the rotation pointer and all credits at once.
module server_pick_balancer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  spb_req_if.sink                        in_if,
  spb_res_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [spb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spb_pkg::*;
  `include "server_pick_balancer_top_defines.svh"

  localparam int SUM_W   = CREDIT_W + 2;
  localparam int TOTAL_W = WEIGHT_BITS + SRV_W;
  localparam int EXT_W   = CONN_BITS + OPEN_W;
  localparam logic signed [SUM_W-1:0] CRED_HI = SUM_W'(2 ** (CREDIT_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] CRED_LO = -CRED_HI - SUM_W'(1);
  localparam logic [CONN_BITS-1:0]    CONN_MAX = '1;
  localparam logic [OPEN_W-1:0]       OPEN_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_DONE, S_RR, S_WSCAN, S_WFIN, S_WCONN, S_LSCAN, S_LFIN, S_HOLD
  } state_t;

  function automatic logic signed [CREDIT_W-1:0] clamp_credit(logic signed [SUM_W-1:0] v);
    if (v > CRED_HI) begin
      return CRED_HI[CREDIT_W-1:0];
    end else if (v < CRED_LO) begin
      return CRED_LO[CREDIT_W-1:0];
    end
    return v[CREDIT_W-1:0];
  endfunction

  function automatic logic [OPEN_W-1:0] sat_open(logic [CONN_BITS-1:0] v);
    if (EXT_W'(v) > EXT_W'(OPEN_MAX)) begin
      return OPEN_MAX;
    end
    return OPEN_W'(v);
  endfunction

  state_t                      state_r, state_nxt;
  logic [MODE_W-1:0]           mode_r, mode_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [CFG_DATA_W-1:0]       weights_r, weights_nxt;
  logic [MASK_W-1:0]           healthy_r, healthy_nxt;
  logic [SRV_W-1:0]            ptr_r, ptr_nxt;
  logic [MAX_SERVERS-1:0]      conn_vld_r, conn_vld_nxt;
  logic [MAX_SERVERS-1:0]      cred_vld_r, cred_vld_nxt;
  logic                        conn_rvld_r, conn_rvld_nxt;
  logic                        cred_rvld_r, cred_rvld_nxt;
  logic [SRV_W-1:0]            di_r, di_nxt;
  logic [SRV_W-1:0]            sel_r, sel_nxt;
  logic signed [CREDIT_W-1:0]  best_r, best_nxt;
  logic [TOTAL_W-1:0]          total_r, total_nxt;
  logic                        found_r, found_nxt;
  logic [CONN_BITS-1:0]        min_r, min_nxt;
  logic [SRV_W-1:0]            hold_idx_r, hold_idx_nxt;
  logic                        hold_none_r, hold_none_nxt;
  logic [OPEN_W-1:0]           hold_cnt_r, hold_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [SRV_W-1:0]            out_idx_r, out_idx_nxt;
  logic                        out_none_r, out_none_nxt;
  logic [OPEN_W-1:0]           out_cnt_r, out_cnt_nxt;

  logic                        conn_we, conn_re;
  logic [SRV_W-1:0]            conn_waddr, conn_raddr;
  logic [CONN_BITS-1:0]        conn_wdata, conn_rdata;
  logic                        cred_we, cred_re;
  logic [SRV_W-1:0]            cred_waddr, cred_raddr;
  logic [CREDIT_W-1:0]         cred_wdata, cred_rdata;

  logic                        accept, fin, res_none, last;
  logic [SRV_W-1:0]            res_idx, p;
  logic [OPEN_W-1:0]           res_cnt;
  logic [CNT_W-1:0]            n_eff;
  logic [CONN_BITS-1:0]        conn_cur;
  logic signed [CREDIT_W-1:0]  cred_cur, newc;
  logic signed [SUM_W-1:0]     sum;
  logic [WEIGHT_BITS-1:0]      w;

  spb_ram #(.DATA_W(CONN_BITS), .DEPTH(MAX_SERVERS)) u_conn_ram (
    .clk   (clk),
    .we    (conn_we),
    .waddr (conn_waddr),
    .wdata (conn_wdata),
    .re    (conn_re),
    .raddr (conn_raddr),
    .rdata (conn_rdata)
  );

  spb_ram #(.DATA_W(CREDIT_W), .DEPTH(MAX_SERVERS)) u_cred_ram (
    .clk   (clk),
    .we    (cred_we),
    .waddr (cred_waddr),
    .wdata (cred_wdata),
    .re    (cred_re),
    .raddr (cred_raddr),
    .rdata (cred_rdata)
  );

  assign in_if.ready         = (state_r == S_IDLE);
  assign accept              = in_if.valid && in_if.ready;
  assign out_if.valid        = out_valid_r;
  assign out_if.server_index = out_idx_r;
  assign out_if.no_server    = out_none_r;
  assign out_if.open_count   = out_cnt_r;

  assign n_eff    = (count_r > CNT_W'(MAX_SERVERS)) ? CNT_W'(MAX_SERVERS) : count_r;
  assign last     = ((CNT_W'(di_r) + CNT_W'(1)) == n_eff);
  assign p        = (CNT_W'(ptr_r) < n_eff) ? ptr_r : '0;
  assign conn_cur = conn_rvld_r ? conn_rdata : '0;
  assign cred_cur = cred_rvld_r ? $signed(cred_rdata) : '0;

  always_comb begin
    w = '0;
    for (int k = 0; k < MAX_SERVERS; k++) begin
      if (di_r == SRV_W'(k)) begin
        w = weights_r[k*WEIGHT_BITS +: WEIGHT_BITS];
      end
    end
  end

  assign sum  = SUM_W'(cred_cur) + signed'(SUM_W'(w));
  assign newc = clamp_credit(sum);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    weights_nxt   = weights_r;
    healthy_nxt   = healthy_r;
    ptr_nxt       = ptr_r;
    conn_vld_nxt  = conn_vld_r;
    cred_vld_nxt  = cred_vld_r;
    di_nxt        = di_r;
    sel_nxt       = sel_r;
    best_nxt      = best_r;
    total_nxt     = total_r;
    found_nxt     = found_r;
    min_nxt       = min_r;
    hold_idx_nxt  = hold_idx_r;
    hold_none_nxt = hold_none_r;
    hold_cnt_nxt  = hold_cnt_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_none_nxt  = out_none_r;
    out_cnt_nxt   = out_cnt_r;
    conn_we       = 1'b0;
    conn_waddr    = sel_r;
    conn_wdata    = '0;
    conn_re       = 1'b0;
    conn_raddr    = '0;
    cred_we       = 1'b0;
    cred_waddr    = di_r;
    cred_wdata    = '0;
    cred_re       = 1'b0;
    cred_raddr    = '0;
    fin           = 1'b0;
    res_idx       = '0;
    res_none      = 1'b0;
    res_cnt       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_if.func == FUNC_DONE) begin
            conn_re    = 1'b1;
            conn_raddr = in_if.done_server;
            sel_nxt    = in_if.done_server;
            state_nxt  = S_DONE;
          end else begin
            case (mode_r)
              MODE_RR: begin
                if (n_eff == '0) begin
                  fin      = 1'b1;
                  res_none = 1'b1;
                end else begin
                  conn_re    = 1'b1;
                  conn_raddr = p;
                  sel_nxt    = p;
                  ptr_nxt    = ((CNT_W'(p) + CNT_W'(1)) >= n_eff) ? '0 : p + SRV_W'(1);
                  state_nxt  = S_RR;
                end
              end
              MODE_SWRR: begin
                if (n_eff == '0) begin
                  fin      = 1'b1;
                  res_none = 1'b1;
                end else begin
                  cred_re   = 1'b1;
                  di_nxt    = '0;
                  found_nxt = 1'b0;
                  total_nxt = '0;
                  state_nxt = S_WSCAN;
                end
              end
              MODE_LC: begin
                if (n_eff == '0) begin
                  fin      = 1'b1;
                  res_none = 1'b1;
                end else begin
                  conn_re   = 1'b1;
                  di_nxt    = '0;
                  state_nxt = S_LSCAN;
                end
              end
              default: begin
                fin      = 1'b1;
                res_none = 1'b1;
              end
            endcase
          end
        end
      end
      S_DONE: begin
        conn_we    = 1'b1;
        conn_wdata = (conn_cur == '0) ? '0 : conn_cur - CONN_BITS'(1);
        conn_vld_nxt[sel_r] = 1'b1;
        fin        = 1'b1;
        res_idx    = sel_r;
        res_cnt    = sat_open(conn_wdata);
      end
      S_RR: begin
        fin     = 1'b1;
        res_idx = sel_r;
        res_cnt = sat_open(conn_cur);
      end
      S_WSCAN: begin
        if (healthy_r[di_r]) begin
          cred_we    = 1'b1;
          cred_wdata = newc;
          cred_vld_nxt[di_r] = 1'b1;
          total_nxt  = total_r + TOTAL_W'(w);
          if (!found_r || (newc > best_r)) begin
            best_nxt  = newc;
            sel_nxt   = di_r;
            found_nxt = 1'b1;
          end
        end
        if (last) begin
          state_nxt = S_WFIN;
        end else begin
          cred_re    = 1'b1;
          cred_raddr = di_r + SRV_W'(1);
          di_nxt     = di_r + SRV_W'(1);
        end
      end
      S_WFIN: begin
        if (!found_r) begin
          fin      = 1'b1;
          res_none = 1'b1;
        end else begin
          cred_we    = 1'b1;
          cred_waddr = sel_r;
          cred_wdata = clamp_credit(SUM_W'(best_r) - signed'(SUM_W'(total_r)));
          cred_vld_nxt[sel_r] = 1'b1;
          conn_re    = 1'b1;
          conn_raddr = sel_r;
          state_nxt  = S_WCONN;
        end
      end
      S_WCONN: begin
        fin     = 1'b1;
        res_idx = sel_r;
        res_cnt = sat_open(conn_cur);
      end
      S_LSCAN: begin
        if ((di_r == '0) || (conn_cur < min_r)) begin
          min_nxt = conn_cur;
          sel_nxt = di_r;
        end
        if (last) begin
          state_nxt = S_LFIN;
        end else begin
          conn_re    = 1'b1;
          conn_raddr = di_r + SRV_W'(1);
          di_nxt     = di_r + SRV_W'(1);
        end
      end
      S_LFIN: begin
        conn_we    = 1'b1;
        conn_wdata = (min_r == CONN_MAX) ? min_r : min_r + CONN_BITS'(1);
        conn_vld_nxt[sel_r] = 1'b1;
        fin        = 1'b1;
        res_idx    = sel_r;
        res_cnt    = sat_open(conn_wdata);
      end
      S_HOLD: begin
        fin      = 1'b1;
        res_idx  = hold_idx_r;
        res_none = hold_none_r;
        res_cnt  = hold_cnt_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (!out_valid_r || out_if.ready) begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = res_idx;
        out_none_nxt  = res_none;
        out_cnt_nxt   = res_cnt;
        state_nxt     = S_IDLE;
      end else begin
        hold_idx_nxt  = res_idx;
        hold_none_nxt = res_none;
        hold_cnt_nxt  = res_cnt;
        state_nxt     = S_HOLD;
      end
    end else if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    conn_rvld_nxt = conn_re ? conn_vld_r[conn_raddr] : conn_rvld_r;
    cred_rvld_nxt = cred_re ? cred_vld_r[cred_raddr] : cred_rvld_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_BALANCE_MODE: begin
          mode_nxt = cfg_data[MODE_W-1:0];
        end
        REG_SERVER_COUNT: begin
          count_nxt    = cfg_data[CNT_W-1:0];
          ptr_nxt      = '0;
          cred_vld_nxt = '0;
        end
        REG_WEIGHTS_PACKED: begin
          weights_nxt = cfg_data;
        end
        REG_HEALTHY_MASK: begin
          healthy_nxt = cfg_data[MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_RR;
      count_r     <= '0;
      weights_r   <= '0;
      healthy_r   <= '1;
      ptr_r       <= '0;
      conn_vld_r  <= '0;
      cred_vld_r  <= '0;
      conn_rvld_r <= 1'b0;
      cred_rvld_r <= 1'b0;
      di_r        <= '0;
      sel_r       <= '0;
      best_r      <= '0;
      total_r     <= '0;
      found_r     <= 1'b0;
      min_r       <= '0;
      hold_idx_r  <= '0;
      hold_none_r <= 1'b0;
      hold_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      out_none_r  <= 1'b0;
      out_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      weights_r   <= weights_nxt;
      healthy_r   <= healthy_nxt;
      ptr_r       <= ptr_nxt;
      conn_vld_r  <= conn_vld_nxt;
      cred_vld_r  <= cred_vld_nxt;
      conn_rvld_r <= conn_rvld_nxt;
      cred_rvld_r <= cred_rvld_nxt;
      di_r        <= di_nxt;
      sel_r       <= sel_nxt;
      best_r      <= best_nxt;
      total_r     <= total_nxt;
      found_r     <= found_nxt;
      min_r       <= min_nxt;
      hold_idx_r  <= hold_idx_nxt;
      hold_none_r <= hold_none_nxt;
      hold_cnt_r  <= hold_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
      out_none_r  <= out_none_nxt;
      out_cnt_r   <= out_cnt_nxt;
    end
  end

  // Reads and writes of one table never meet at the same entry in one cycle.
  `SPB_ASSERT_NEVER(a_conn_rw_clash, conn_we && conn_re && (conn_waddr == conn_raddr), "connection table read and written at the same entry")
  `SPB_ASSERT_NEVER(a_cred_rw_clash, cred_we && cred_re && (cred_waddr == cred_raddr), "credit table read and written at the same entry")
  `SPB_ASSERT(a_scan_in_range, ((state_r == S_WSCAN) || (state_r == S_LSCAN)) |-> (CNT_W'(di_r) < n_eff), "scan index beyond the server count")
  `SPB_ASSERT(a_none_is_zero, (out_valid_r && out_none_r) |-> ((out_idx_r == '0) && (out_cnt_r == '0)), "no-server result carries a server or a count")

endmodule

/* design/spb_ram.sv */
// Simple dual-port memory of the balancer: one write port, one read port, registered read.
// Depends on nothing.
module spb_ram #(
  parameter  int DATA_W = 8,
  parameter  int DEPTH  = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
